// ===== rtl/core/vlti_pkg.sv =====
// ----------------------------------------------------------------------------
// VLAN tag insert/strip package
// Shared widths, constants, codes and the beat-group type passed between the
// rewrite stage and the emit stage.
// ----------------------------------------------------------------------------
package vlti_pkg;

  // Field widths.
  localparam int IdxW    = 11;
  localparam int LenW    = 12;
  localparam int VidW    = 12;
  localparam int PriW    = 3;
  localparam int GrpMax  = 6;
  localparam int CntW    = $clog2(GrpMax + 1);
  localparam int PosW    = $clog2(GrpMax);
  localparam int CmpW    = 15;

  // Frame size limits.
  localparam int unsigned MaxFrameBytes = 2048;
  localparam int unsigned CountLimit    = 2048;
  localparam logic [CmpW-1:0] MaxFrameCmp = CmpW'(MaxFrameBytes);
  localparam logic [LenW-1:0] CountLimitLen = LenW'(CountLimit);
  localparam logic [IdxW-1:0] IdxMax = IdxW'(CountLimit - 1);

  // Minimum lengths per operation.
  localparam logic [LenW-1:0] MinLenAdd    = LenW'(14);
  localparam logic [LenW-1:0] MinLenRemove = LenW'(18);
  localparam logic [LenW-1:0] MinLenRetag  = LenW'(16);
  localparam logic [CmpW-1:0] TagGrowth    = CmpW'(4);

  // Byte positions of the tag within the frame.
  localparam logic [IdxW-1:0] TpidHiPos = IdxW'(12);
  localparam logic [IdxW-1:0] TpidLoPos = IdxW'(13);
  localparam logic [IdxW-1:0] TciHiPos  = IdxW'(14);
  localparam logic [IdxW-1:0] TciLoPos  = IdxW'(15);

  // Tag protocol identifier bytes.
  localparam logic [7:0] TpidHi = 8'h81;
  localparam logic [7:0] TpidLo = 8'h00;
  localparam logic [3:0] VidHiMask = 4'h0F;

  typedef enum logic {
    FUNC_ADD    = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_LARGE = 2'd2
  } status_e;

  // One input beat turned into a group of one, two or six output beats.
  typedef struct packed {
    logic [GrpMax-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
    logic                   last;
    status_e                status;
    logic [VidW-1:0]        vid;
    logic [PriW-1:0]        pri;
  } group_t;

  // Upper tag control byte: priority, drop-eligible bit clear, top of the id.
  function automatic logic [7:0] tci_hi(input logic [PriW-1:0] pri,
                                        input logic [VidW-1:0] vid);
    tci_hi = {pri, 1'b0, vid[VidW-1:8] & VidHiMask};
  endfunction

endpackage

// ===== rtl/core/vlti_in_if.sv =====
// ----------------------------------------------------------------------------
// VLAN tag insert/strip input channel
// Valid/ready channel carrying one frame byte and its per-frame controls.
// ----------------------------------------------------------------------------
interface vlti_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [7:0]                data_byte;
  logic [vlti_pkg::LenW-1:0] frame_length;
  logic [vlti_pkg::VidW-1:0] vlan_id;
  logic [vlti_pkg::PriW-1:0] priority_req;

  modport source (
    output valid, func, data_byte, frame_length, vlan_id, priority_req,
    input  ready
  );
  modport sink (
    input  valid, func, data_byte, frame_length, vlan_id, priority_req,
    output ready
  );
endinterface

// ===== rtl/core/vlti_out_if.sv =====
// ----------------------------------------------------------------------------
// VLAN tag insert/strip output channel
// Valid/ready channel carrying one rewritten frame byte with its metadata.
// ----------------------------------------------------------------------------
interface vlti_out_if;
  logic                      valid;
  logic                      ready;
  logic [7:0]                out_byte;
  logic                      out_last;
  logic [1:0]                status;
  logic [vlti_pkg::VidW-1:0] tag_vlan_id;
  logic [vlti_pkg::PriW-1:0] tag_priority;

  modport source (
    output valid, out_byte, out_last, status, tag_vlan_id, tag_priority,
    input  ready
  );
  modport sink (
    input  valid, out_byte, out_last, status, tag_vlan_id, tag_priority,
    output ready
  );
endinterface

// ===== rtl/core/vlti_rewrite.sv =====
// ----------------------------------------------------------------------------
// VLAN tag rewrite stage
// Tracks the frame position, decides per input beat which output beats it
// causes, and registers that beat group for the emit stage.
// ----------------------------------------------------------------------------
module vlti_rewrite (
  input  logic              clk_i,
  input  logic              rst_ni,
  vlti_in_if.sink           in_i,
  input  logic              take_i,
  output logic              grp_valid_o,
  output vlti_pkg::group_t  grp_o
);
  import vlti_pkg::*;

  logic [IdxW-1:0] byte_index_q;
  logic [7:0]      held_byte_q, held_byte_d;
  logic            tagged_q, tagged_d;
  status_e         status_q, status_d;
  logic            grp_valid_q;
  group_t          grp_q, grp_d;

  logic [LenW-1:0] len, eff;
  logic [IdxW-1:0] idx;
  logic [7:0]      b, hi_byte, lo_byte;
  logic            is_last, has_tag, is_add, accept;
  status_e         status_init, status_cur;
  logic            tagged_cur;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = !grp_valid_q || take_i;

  // Decide the output beats of the current input beat.
  always_comb begin
    len     = in_i.frame_length;
    b       = in_i.data_byte;
    idx     = byte_index_q;
    is_add  = (func_e'(in_i.func) == FUNC_ADD);
    hi_byte = tci_hi(in_i.priority_req, in_i.vlan_id);
    lo_byte = in_i.vlan_id[7:0];
    eff     = (len > CountLimitLen) ? CountLimitLen : len;
    is_last = (({1'b0, idx} + LenW'(1)) >= eff);
    has_tag = (held_byte_q == TpidHi) && (b == TpidLo);

    if ({3'b000, len} > MaxFrameCmp) begin
      status_init = ST_LARGE;
    end else if (len < (is_add ? MinLenAdd : MinLenRemove)) begin
      status_init = ST_SHORT;
    end else begin
      status_init = ST_OK;
    end
    status_cur = (idx == '0) ? status_init : status_q;
    tagged_cur = (idx == '0) ? 1'b0 : tagged_q;

    status_d    = status_cur;
    tagged_d    = tagged_cur;
    held_byte_d = held_byte_q;
    grp_d       = '0;
    grp_d.bytes[0] = b;
    grp_d.cnt   = CntW'(1);

    if (status_cur != ST_OK || idx < TpidHiPos || idx > TciLoPos) begin
      grp_d.cnt = CntW'(1);
    end else if (idx == TpidHiPos) begin
      // Hold the first tag byte until its partner arrives.
      if (!is_last) begin
        grp_d.cnt   = '0;
        held_byte_d = b;
      end
    end else if (idx == TpidLoPos) begin
      grp_d.bytes[0] = held_byte_q;
      grp_d.bytes[1] = b;
      grp_d.cnt      = CntW'(2);
      if (is_add) begin
        if (has_tag) begin
          if (len < MinLenRetag) begin
            status_d = ST_SHORT;
          end else begin
            tagged_d = 1'b1;
          end
        end else if (({3'b000, len} + TagGrowth) > MaxFrameCmp) begin
          status_d = ST_LARGE;
        end else begin
          // Insert a full tag ahead of the held byte.
          grp_d.bytes[0] = TpidHi;
          grp_d.bytes[1] = TpidLo;
          grp_d.bytes[2] = hi_byte;
          grp_d.bytes[3] = lo_byte;
          grp_d.bytes[4] = held_byte_q;
          grp_d.bytes[5] = b;
          grp_d.cnt      = CntW'(6);
        end
      end else if (has_tag) begin
        tagged_d       = 1'b1;
        grp_d.bytes[0] = b;
        grp_d.cnt      = is_last ? CntW'(1) : '0;
      end
    end else begin
      // Tag control bytes: rewrite on add, drop on remove.
      if (tagged_cur) begin
        if (is_add) begin
          grp_d.bytes[0] = (idx == TciHiPos) ? hi_byte : lo_byte;
        end else begin
          grp_d.cnt = is_last ? CntW'(1) : '0;
        end
      end
    end

    grp_d.last   = is_last;
    grp_d.status = status_d;
    if (status_d == ST_OK && is_add) begin
      grp_d.vid = in_i.vlan_id;
      grp_d.pri = in_i.priority_req;
    end
  end

  // Frame state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      held_byte_q  <= '0;
      tagged_q     <= 1'b0;
      status_q     <= ST_OK;
    end else if (accept) begin
      held_byte_q <= held_byte_d;
      if (is_last) begin
        byte_index_q <= '0;
        tagged_q     <= 1'b0;
        status_q     <= ST_OK;
      end else begin
        byte_index_q <= (byte_index_q < IdxMax) ? byte_index_q + IdxW'(1) : IdxMax;
        tagged_q     <= tagged_d;
        status_q     <= status_d;
      end
    end
  end

  // Beat-group register toward the emit stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
    end else if (accept && grp_d.cnt != '0) begin
      grp_valid_q <= 1'b1;
    end else if (take_i) begin
      grp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && grp_d.cnt != '0) begin
      grp_q <= grp_d;
    end
  end

  assign grp_valid_o = grp_valid_q;
  assign grp_o       = grp_q;

  // The frame position restarts after the last byte of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_last |=> byte_index_q == '0)
    else $error("byte index not cleared after last byte");

  // A registered group always holds one, two or six beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q |-> (grp_q.cnt == CntW'(1) || grp_q.cnt == CntW'(2) ||
                     grp_q.cnt == CntW'(6)))
    else $error("beat group with bad count");

  // A group waiting for the emit stage is not overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_q && !take_i |=> grp_valid_q && $stable(grp_q))
    else $error("pending beat group lost");

endmodule

// ===== rtl/core/vlti_emit.sv =====
// ----------------------------------------------------------------------------
// VLAN tag emit stage
// Holds one beat group and sends its bytes out one beat per cycle while the
// receiver is ready, putting the end-of-frame metadata on the final beat only.
// ----------------------------------------------------------------------------
module vlti_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              grp_valid_i,
  input  vlti_pkg::group_t  grp_i,
  output logic              take_o,
  vlti_out_if.source        out_o
);
  import vlti_pkg::*;

  logic            valid_q;
  group_t          grp_q;
  logic [PosW-1:0] pos_q;
  logic            final_beat, frame_end, load;

  assign final_beat = (CntW'(pos_q) == grp_q.cnt - CntW'(1));
  assign take_o     = !valid_q || (out_o.ready && final_beat);
  assign load       = take_o && grp_valid_i;
  assign frame_end  = final_beat && grp_q.last;

  // Group register and beat position.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else if (take_o) begin
      valid_q <= grp_valid_i;
      pos_q   <= '0;
    end else if (out_o.ready) begin
      pos_q <= pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      grp_q <= grp_i;
    end
  end

  // Output beat.
  always_comb begin
    out_o.valid        = valid_q;
    out_o.out_byte     = grp_q.bytes[pos_q];
    out_o.out_last     = frame_end;
    out_o.status       = frame_end ? grp_q.status : ST_OK;
    out_o.tag_vlan_id  = frame_end ? grp_q.vid : '0;
    out_o.tag_priority = frame_end ? grp_q.pri : '0;
  end

  // The beat position never runs past the group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> CntW'(pos_q) < grp_q.cnt)
    else $error("beat position beyond group");

  // Error status only travels on the last beat of a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !frame_end |-> out_o.status == ST_OK)
    else $error("status on a beat that does not end the frame");

endmodule

// ===== rtl/core/vlan_tag_insert_strip_top.sv =====
// ----------------------------------------------------------------------------
// VLAN tag insert/strip top level
// Adds, rewrites or removes an 802.1Q tag on a byte-wide Ethernet frame.
// ----------------------------------------------------------------------------
// Path: an accepted input byte is registered in the rewrite stage, then in the
//   emit stage, before its first output beat appears.
// Throughput: one byte per cycle while the receiver is ready; byte 13 can turn
//   into two output beats, or six (tag insert), which stall the input meanwhile.
// Reset: rst_ni is asynchronous and active low; it clears the frame position,
//   frame status and both stage valids. No clearing pass is needed.
module vlan_tag_insert_strip_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  vlti_in_if.sink    in_i,
  vlti_out_if.source out_o
);
  import vlti_pkg::*;

  logic   grp_valid;
  logic   take;
  group_t grp;

  // Frame tracking and beat-group decision.
  vlti_rewrite u_rewrite (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .take_i      (take),
    .grp_valid_o (grp_valid),
    .grp_o       (grp)
  );

  // Beat-by-beat output.
  vlti_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_i       (grp),
    .take_o      (take),
    .out_o       (out_o)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// VLAN tag insert/strip testbench
// Sends whole frames, byte by byte, into the tag insert/strip block. A short
// table of frames covers the length limits, tag rewrite and strip cases and
// frames cut short. Random frames follow under four idle and stall mixes.
// Every output beat is compared with a bytewise model of the rewrite.
// ----------------------------------------------------------------------------
module tb_top;
  import vlti_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 3;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned FRAMES_PER_PHASE = 2;
  localparam int unsigned MAX_REPORTS  = 50;

  // Frame limits and tag bytes, as the rewrite defines them.
  localparam int unsigned MAX_BYTES  = 2048;
  localparam int unsigned MIN_ADD    = 14;
  localparam int unsigned MIN_REMOVE = 18;
  localparam int unsigned MIN_RETAG  = 16;
  localparam int unsigned TAG_BYTES  = 4;
  localparam int unsigned LAST_POS   = 2047;
  localparam logic [7:0]  TPID_HI    = 8'h81;
  localparam logic [7:0]  TPID_LO    = 8'h00;

  // What bytes 12 and 13 of a generated frame carry.
  typedef enum logic [1:0] {
    TP_NONE,
    TP_TAG,
    TP_HALF_HI,
    TP_HALF_LO
  } tpid_e;

  typedef struct {
    func_e            fn;
    logic [7:0]       data;
    logic [LenW-1:0]  len;
    logic [VidW-1:0]  vid;
    logic [PriW-1:0]  pri;
  } in_beat_t;

  typedef struct {
    logic [7:0]       data;
    logic             last;
    status_e          st;
    logic [VidW-1:0]  vid;
    logic [PriW-1:0]  pri;
  } out_beat_t;

  typedef struct {
    func_e            fn;
    logic [LenW-1:0]  len;
    int unsigned      cut_at;
    tpid_e            tpid;
    logic [VidW-1:0]  vid;
    logic [PriW-1:0]  pri;
    bit               noisy;
    bit               typed;
    status_e          st;
    logic [VidW-1:0]  t_vid;
    logic [PriW-1:0]  t_pri;
  } frame_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  vlti_in_if  in_if ();
  vlti_out_if out_if ();

  vlan_tag_insert_strip_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Rewrite model state.
  logic [IdxW-1:0] frame_pos;
  logic [7:0]      held_byte;
  bit              tag_seen;
  status_e         frame_err;

  out_beat_t   rewritten_q[$];
  out_beat_t   want_beat;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  // Directed frames. Status and tag metadata are typed in where they are
  // plain to see; the byte stream itself always comes from the model.
  frame_row_t dir_rows [7] = '{
    '{FUNC_ADD,    12'd0,    0, TP_NONE, 12'h123, 3'd1, 0, 1, ST_SHORT, 12'h0,   3'd0},
    '{FUNC_REMOVE, 12'd17,   2, TP_TAG,  12'h111, 3'd1, 0, 1, ST_SHORT, 12'h0,   3'd0},
    '{FUNC_ADD,    12'd14,   0, TP_NONE, 12'hFFF, 3'd7, 0, 1, ST_OK,    12'hFFF, 3'd7},
    '{FUNC_ADD,    12'd14,   0, TP_TAG,  12'hABC, 3'd5, 0, 1, ST_SHORT, 12'h0,   3'd0},
    '{FUNC_ADD,    12'd16,   0, TP_TAG,  12'h000, 3'd0, 0, 1, ST_OK,    12'h000, 3'd0},
    '{FUNC_REMOVE, 12'd18,   0, TP_TAG,  12'h222, 3'd2, 0, 1, ST_OK,    12'h0,   3'd0},
    '{FUNC_ADD,    12'd2045, 15, TP_NONE, 12'h0F0, 3'd1, 0, 1, ST_LARGE, 12'h0,   3'd0}
  };

  // A frame longer than the size limit, cut short after two bytes.
  frame_row_t huge_row = '{FUNC_ADD, 12'hFFF, 2, TP_TAG, 12'h5A5, 3'd6, 0, 1, ST_LARGE,
                           12'h0, 3'd0};

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic out_beat_t plain(input logic [7:0] b);
    out_beat_t ob;
    ob.data = b;
    ob.last = 1'b0;
    ob.st   = ST_OK;
    ob.vid  = '0;
    ob.pri  = '0;
    return ob;
  endfunction

  // Rewrites one accepted input byte and queues the output beats it causes.
  function automatic void vlan_rewrite(input in_beat_t ib, output bit frame_end);
    logic [7:0]  tci_hi_b;
    logic [7:0]  tci_lo_b;
    int unsigned eff_len;
    bit          has_tag;
    int unsigned pos;
    out_beat_t   grp[$];
    tci_hi_b = {ib.pri, 1'b0, ib.vid[11:8]};
    tci_lo_b = ib.vid[7:0];
    eff_len  = (ib.len > MAX_BYTES) ? MAX_BYTES : ib.len;
    pos      = frame_pos;

    // Length checks on the first byte of a frame.
    if (pos == 0) begin
      tag_seen = 1'b0;
      if (ib.len > MAX_BYTES)
        frame_err = ST_LARGE;
      else if (ib.len < ((ib.fn == FUNC_REMOVE) ? MIN_REMOVE : MIN_ADD))
        frame_err = ST_SHORT;
      else
        frame_err = ST_OK;
    end
    frame_end = (pos + 1 >= eff_len);

    if (frame_err != ST_OK || pos < 12 || pos > 15) begin
      grp.push_back(plain(ib.data));
    end else if (pos == 12) begin
      // Byte 12 waits for byte 13 unless it ends the frame.
      if (frame_end)
        grp.push_back(plain(ib.data));
      else
        held_byte = ib.data;
    end else if (pos == 13) begin
      has_tag = (held_byte == TPID_HI) && (ib.data == TPID_LO);
      if (ib.fn == FUNC_ADD) begin
        if (has_tag) begin
          if (ib.len < MIN_RETAG)
            frame_err = ST_SHORT;
          else
            tag_seen = 1'b1;
          grp.push_back(plain(held_byte));
          grp.push_back(plain(ib.data));
        end else if (ib.len + TAG_BYTES > MAX_BYTES) begin
          frame_err = ST_LARGE;
          grp.push_back(plain(held_byte));
          grp.push_back(plain(ib.data));
        end else begin
          grp.push_back(plain(TPID_HI));
          grp.push_back(plain(TPID_LO));
          grp.push_back(plain(tci_hi_b));
          grp.push_back(plain(tci_lo_b));
          grp.push_back(plain(held_byte));
          grp.push_back(plain(ib.data));
        end
      end else if (has_tag) begin
        tag_seen = 1'b1;
        if (frame_end)
          grp.push_back(plain(ib.data));
      end else begin
        grp.push_back(plain(held_byte));
        grp.push_back(plain(ib.data));
      end
    end else begin
      // Tag control bytes: rewritten on add, dropped on remove.
      if (tag_seen) begin
        if (ib.fn == FUNC_ADD)
          grp.push_back(plain((pos == 14) ? tci_hi_b : tci_lo_b));
        else if (frame_end)
          grp.push_back(plain(ib.data));
      end else begin
        grp.push_back(plain(ib.data));
      end
    end

    // The last output beat carries the frame status and tag metadata.
    if (frame_end) begin
      if (grp.size() > 0) begin
        grp[grp.size() - 1].last = 1'b1;
        grp[grp.size() - 1].st   = frame_err;
        if (frame_err == ST_OK && ib.fn == FUNC_ADD) begin
          grp[grp.size() - 1].vid = ib.vid;
          grp[grp.size() - 1].pri = ib.pri;
        end
      end
      frame_pos = '0;
      tag_seen  = 1'b0;
      frame_err = ST_OK;
    end else begin
      frame_pos = (pos < LAST_POS) ? IdxW'(pos + 1) : IdxW'(LAST_POS);
    end
    foreach (grp[i]) rewritten_q.push_back(grp[i]);
  endfunction

  // Builds byte number idx of a frame.
  function automatic in_beat_t frame_byte(input frame_row_t fr, input int unsigned idx);
    in_beat_t ib;
    ib.fn   = fr.fn;
    ib.data = 8'($urandom);
    ib.len  = (fr.cut_at != 0 && idx == fr.cut_at - 1) ? LenW'(fr.cut_at) : fr.len;
    ib.vid  = fr.vid;
    ib.pri  = fr.pri;
    if (idx == 12) begin
      if (fr.tpid == TP_TAG || fr.tpid == TP_HALF_HI)
        ib.data = TPID_HI;
      else if ((fr.tpid == TP_HALF_LO || fr.tpid == TP_NONE) && ib.data == TPID_HI)
        ib.data = 8'h88;
    end else if (idx == 13) begin
      if (fr.tpid == TP_TAG || fr.tpid == TP_HALF_LO)
        ib.data = TPID_LO;
      else if (fr.tpid == TP_HALF_HI)
        ib.data = 8'($urandom_range(255, 1));
    end
    // Noisy frames change every per-byte control on every byte.
    if (fr.noisy) begin
      ib.fn  = func_e'($urandom_range(1));
      ib.len = ($urandom_range(1) == 0) ? LenW'($urandom) : LenW'($urandom_range(40));
      ib.vid = VidW'($urandom);
      ib.pri = PriW'($urandom);
    end
    return ib;
  endfunction

  function automatic frame_row_t random_frame();
    frame_row_t  fr;
    int unsigned pick;
    fr.fn    = func_e'($urandom_range(1));
    fr.vid   = VidW'($urandom);
    fr.pri   = PriW'($urandom);
    fr.noisy = ($urandom_range(99) < 12);
    fr.typed = 1'b0;
    fr.st    = ST_OK;
    fr.t_vid = '0;
    fr.t_pri = '0;
    pick = $urandom_range(99);
    if (pick < 45)
      fr.tpid = TP_TAG;
    else if (pick < 52)
      fr.tpid = TP_HALF_HI;
    else if (pick < 59)
      fr.tpid = TP_HALF_LO;
    else
      fr.tpid = TP_NONE;
    fr.cut_at = ($urandom_range(9) == 0) ? $urandom_range(20, 1) : 0;
    // Mostly short frames; a few near or past the size limit, always cut short.
    pick = $urandom_range(99);
    if (pick < 5) begin
      case ($urandom_range(3))
        0:       fr.len = 12'd2044;
        1:       fr.len = 12'd2045;
        2:       fr.len = 12'd2048;
        default: fr.len = LenW'($urandom_range(4095, 1024));
      endcase
      fr.cut_at = $urandom_range(16, 2);
    end else if (pick < 20) begin
      fr.len = LenW'($urandom_range(13));
    end else begin
      fr.len = LenW'($urandom_range(16, 14));
    end
    return fr;
  endfunction

  // Drives one input beat, waits for it to be taken, then models it.
  task automatic push_byte(input in_beat_t ib, output bit frame_end);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.func         <= ib.fn;
    in_if.data_byte    <= ib.data;
    in_if.frame_length <= ib.len;
    in_if.vlan_id      <= ib.vid;
    in_if.priority_req <= ib.pri;
    do @(posedge clk_i); while (!in_if.ready);
    vlan_rewrite(ib, frame_end);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input frame_row_t fr);
    in_beat_t    ib;
    bit          frame_end;
    int unsigned idx;
    int unsigned tail;
    idx = 0;
    do begin
      ib = frame_byte(fr, idx);
      push_byte(ib, frame_end);
      idx++;
    end while (!frame_end);
    // The frame's last beat has not reached the output yet, so it can be patched.
    if (fr.typed) begin
      tail = rewritten_q.size() - 1;
      rewritten_q[tail].st  = fr.st;
      rewritten_q[tail].vid = fr.t_vid;
      rewritten_q[tail].pri = fr.t_pri;
    end
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_REPORTS)
      $display("%0t tb_top: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Receiver stalls.
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Output check against the oldest expected beat.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (rewritten_q.size() == 0) begin
        flag_mismatch("beat with nothing pending", out_if.out_byte, 0);
      end else begin
        want_beat = rewritten_q.pop_front();
        if (out_if.out_byte !== want_beat.data)
          flag_mismatch("out_byte", out_if.out_byte, want_beat.data);
        if (out_if.out_last !== want_beat.last)
          flag_mismatch("out_last", out_if.out_last, want_beat.last);
        if (out_if.status !== want_beat.st)
          flag_mismatch("status", out_if.status, want_beat.st);
        if (out_if.tag_vlan_id !== want_beat.vid)
          flag_mismatch("tag_vlan_id", out_if.tag_vlan_id, want_beat.vid);
        if (out_if.tag_priority !== want_beat.pri)
          flag_mismatch("tag_priority", out_if.tag_priority, want_beat.pri);
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t tb_top: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    frame_pos          = '0;
    held_byte          = '0;
    tag_seen           = 1'b0;
    frame_err          = ST_OK;
    mismatches         = 0;
    quiet_cycles       = 0;
    src_idle_pct       = 0;
    snk_stall_pct      = 0;
    rst_ni             = 1'b0;
    in_if.valid        = 1'b0;
    in_if.func         = FUNC_ADD;
    in_if.data_byte    = '0;
    in_if.frame_length = '0;
    in_if.vlan_id      = '0;
    in_if.priority_req = '0;
    out_if.ready       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed frames with no idling.
    foreach (dir_rows[i]) send_frame(dir_rows[i]);
    send_frame(huge_row);

    // Random frames under four idle and stall mixes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
        default: begin src_idle_pct = 29; snk_stall_pct = 29; end
      endcase
      repeat (FRAMES_PER_PHASE) send_frame(random_frame());
    end
    in_if.valid <= 1'b0;

    // Drain; the watchdog catches beats that never come.
    while (rewritten_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
